/* rtl/constraint_graph_colorer_macros.svh */
// Assertion macros for the constraint graph colorer
`ifndef CONSTRAINT_GRAPH_COLORER_MACROS_SVH
`define CONSTRAINT_GRAPH_COLORER_MACROS_SVH
`ifndef ASSERT_OFF
`define CGC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define CGC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assert failed");
`else
`define CGC_ASSERT(label, clk, rst_n, prop)
`define CGC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/cgc_pkg.sv */
// Shared types and constants of the constraint graph colorer
`timescale 1ns / 1ps
`default_nettype none
package cgc_pkg;
  localparam int unsigned BodyCountDef = 1024;
  localparam int unsigned StaticColorsDef = 4;
  localparam int unsigned DynamicColorsDef = 8;
  localparam int unsigned SlotsPerColorDef = 256;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpFlush = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic kind;
    logic [9:0] body_a;
    logic [9:0] body_b;
    logic dynamic_a;
    logic dynamic_b;
    logic [15:0] constraint_id;
    logic [3:0] given_color;
    logic [7:0] given_slot;
    logic invalid;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle, StRead, StDecide, StMove, StClear, StOut, StWipe
  } be_state_e;
endpackage
`default_nettype wire

/* rtl/cgc_front.sv */
// Front end: accepts transactions, classifies them and queues them
`timescale 1ns / 1ps
`default_nettype none
`include "constraint_graph_colorer_macros.svh"
module cgc_front import cgc_pkg::*; #(
  parameter int unsigned BODY_COUNT = BodyCountDef,
  parameter int unsigned STATIC_COLORS = StaticColorsDef,
  parameter int unsigned DYNAMIC_COLORS = DynamicColorsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire cmd_t cmd_i,
  output logic q_valid_o,
  input  wire logic q_take_i,
  output cmd_t q_cmd_o
);
  localparam int unsigned ColorTotal = STATIC_COLORS + DYNAMIC_COLORS + 1;
  cmd_t buf_q [2];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;
  cmd_t cls;
  logic push, pop;

  always_comb begin
    cls = cmd_i;
    cls.invalid = 1'b0;
    if (cmd_i.opcode != OpFlush) begin
      if (cmd_i.opcode != OpAdd && cmd_i.opcode != OpRemove) cls.invalid = 1'b1;
      if (32'(cmd_i.body_a) >= BODY_COUNT || 32'(cmd_i.body_b) >= BODY_COUNT)
        cls.invalid = 1'b1;
      if (cmd_i.opcode == OpRemove && 32'(cmd_i.given_color) >= ColorTotal)
        cls.invalid = 1'b1;
    end
  end

  assign in_stall_o = cnt_q == 2'd2;
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop = q_valid_o && q_take_i;
  assign q_cmd_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `CGC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2)
  `CGC_ASSERT_NEXT(a_full_stall, clk_i, rst_ni, cnt_q == 2'd2 && !pop, in_stall_o)
  `CGC_ASSERT_NEXT(a_push_vis, clk_i, rst_ni, push, q_valid_o)
endmodule
`default_nettype wire

/* rtl/cgc_back.sv */
// Back end: mask and slot memories, color pick, slot append and swap remove
`timescale 1ns / 1ps
`default_nettype none
`include "constraint_graph_colorer_macros.svh"
module cgc_back import cgc_pkg::*; #(
  parameter int unsigned BODY_COUNT = BodyCountDef,
  parameter int unsigned STATIC_COLORS = StaticColorsDef,
  parameter int unsigned DYNAMIC_COLORS = DynamicColorsDef,
  parameter int unsigned SLOTS_PER_COLOR = SlotsPerColorDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  output logic q_take_o,
  input  wire cmd_t q_cmd_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [3:0] color_o,
  output logic [7:0] slot_o,
  output logic [15:0] moved_id_o,
  output logic moved_o,
  output logic [1:0] status_o
);
  localparam int unsigned MaskW = STATIC_COLORS + DYNAMIC_COLORS;
  localparam int unsigned ColorTotal = MaskW + 1;
  localparam int unsigned Tables = 2 * ColorTotal;
  localparam int unsigned BodyW = $clog2(BODY_COUNT);
  localparam int unsigned TabW = $clog2(Tables);
  localparam int unsigned SlotW = $clog2(SLOTS_PER_COLOR);
  localparam int unsigned CntW = SlotW + 1;
  localparam int unsigned AddrW = TabW + SlotW;
  localparam int unsigned ColW = $clog2(ColorTotal);
  localparam int unsigned EpochW = 16;

  // masks carry an epoch tag so that a flush advances the epoch instead of clearing every mask
  logic [MaskW-1:0] mask_mem [BODY_COUNT];
  logic [EpochW-1:0] tag_mem [BODY_COUNT];
  logic [15:0] slot_mem [Tables*SLOTS_PER_COLOR];
  logic [CntW-1:0] cnt_q [Tables];
  logic [EpochW-1:0] epoch_q;
  logic flush_pend_q;
  logic [BodyW-1:0] wipe_q;

  be_state_e st_q, st_d;
  cmd_t cmd_q;
  logic [MaskW-1:0] ma_raw_q, mb_raw_q;
  logic [EpochW-1:0] ta_q, tb_q;
  logic [15:0] mid_q;
  logic [ColW-1:0] col_q;
  logic [TabW-1:0] tab_q;
  logic [CntW-1:0] n_q;
  logic [3:0] o_color_q;
  logic [7:0] o_slot_q;
  logic [15:0] o_id_q;
  logic o_moved_q;
  logic [1:0] o_status_q;
  logic [MaskW-1:0] ma, mb;
  logic [ColW-1:0] pick;
  logic [BodyW-1:0] ia, ib;
  logic [TabW-1:0] rtab;

  assign ia = BodyW'(cmd_q.body_a);
  assign ib = BodyW'(cmd_q.body_b);
  assign ma = (ta_q == epoch_q) ? ma_raw_q : '0;
  assign mb = (tb_q == epoch_q) ? mb_raw_q : '0;
  // table a remove points at, known before the decide cycle
  assign rtab = TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(cmd_q.given_color);

  always_comb begin
    pick = ColW'(MaskW);
    if (cmd_q.dynamic_a && cmd_q.dynamic_b) begin
      for (int c = MaskW - 1; c >= int'(STATIC_COLORS); c--)
        if (!(ma[c] | mb[c])) pick = ColW'(c);
    end else if (cmd_q.dynamic_a || cmd_q.dynamic_b) begin
      for (int c = STATIC_COLORS - 1; c >= 0; c--)
        if (!(cmd_q.dynamic_a ? ma[c] : mb[c])) pick = ColW'(c);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (flush_pend_q) st_d = StClear;
        else if (q_valid_i) st_d = StRead;
      StRead: st_d = StDecide;
      StDecide: st_d = StMove;
      StMove: st_d = StOut;
      StClear: if (epoch_q == '1) st_d = StWipe;
        else st_d = StIdle;
      StOut: if (!out_stall_i) st_d = StIdle;
      StWipe: if (wipe_q == BodyW'(BODY_COUNT - 1)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign q_take_o = st_q == StIdle && !flush_pend_q && q_valid_i;
  assign out_valid_o = st_q == StOut;
  assign color_o = o_color_q;
  assign slot_o = o_slot_q;
  assign moved_id_o = o_id_q;
  assign moved_o = o_moved_q;
  assign status_o = o_status_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (st_q == StRead) begin
      ma_raw_q <= mask_mem[ia];
      mb_raw_q <= mask_mem[ib];
      ta_q <= tag_mem[ia];
      tb_q <= tag_mem[ib];
    end
    // epoch 0 is never live, so a zero tag reads as an empty mask
    if (st_q == StWipe) tag_mem[wipe_q] <= '0;
    if (st_q == StMove && o_status_q == StatusOk && col_q != ColW'(MaskW)) begin
      if (cmd_q.opcode == OpAdd) begin
        if (col_q >= ColW'(STATIC_COLORS) || cmd_q.dynamic_a) begin
          mask_mem[ia] <= ma | (MaskW'(1) << col_q);
          tag_mem[ia] <= epoch_q;
        end
        if (col_q >= ColW'(STATIC_COLORS) || !cmd_q.dynamic_a) begin
          mask_mem[ib] <= (ia == ib && col_q >= ColW'(STATIC_COLORS))
            ? ma | mb | (MaskW'(1) << col_q) : mb | (MaskW'(1) << col_q);
          tag_mem[ib] <= epoch_q;
        end
      end else if (cmd_q.opcode == OpRemove) begin
        mask_mem[ia] <= ma & ~(MaskW'(1) << col_q);
        tag_mem[ia] <= epoch_q;
        mask_mem[ib] <= mb & ~(MaskW'(1) << col_q);
        tag_mem[ib] <= epoch_q;
      end
    end
  end

  // slot table: one write and one read port
  always_ff @(posedge clk_i) begin
    if (st_q == StDecide) mid_q <= slot_mem[AddrW'(rtab) * AddrW'(SLOTS_PER_COLOR)
        + AddrW'(cnt_q[rtab] - CntW'(1))];
    if (st_q == StMove && cmd_q.opcode == OpAdd && o_status_q == StatusOk)
      slot_mem[AddrW'(tab_q) * AddrW'(SLOTS_PER_COLOR) + AddrW'(n_q)]
        <= cmd_q.constraint_id;
    if (st_q == StMove && cmd_q.opcode == OpRemove && o_status_q == StatusOk && o_moved_q)
      slot_mem[AddrW'(tab_q) * AddrW'(SLOTS_PER_COLOR) + AddrW'(cmd_q.given_slot)]
        <= mid_q;
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o) cmd_q <= q_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StWipe;
      epoch_q <= EpochW'(1);
      flush_pend_q <= 1'b0;
      wipe_q <= '0;
      for (int t = 0; t < int'(Tables); t++) cnt_q[t] <= '0;
      col_q <= '0;
      tab_q <= '0;
      n_q <= '0;
      o_color_q <= '0;
      o_slot_q <= '0;
      o_id_q <= '0;
      o_moved_q <= 1'b0;
      o_status_q <= StatusOk;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: ;
        StRead: ;
        StDecide: begin
          o_color_q <= '0; o_slot_q <= '0; o_id_q <= '0;
          o_moved_q <= 1'b0; o_status_q <= StatusOk;
          if (cmd_q.opcode == OpFlush) begin
            flush_pend_q <= 1'b1;
          end else if (cmd_q.invalid) begin
            o_status_q <= StatusInvalid;
          end else if (cmd_q.opcode == OpAdd) begin
            col_q <= pick;
            tab_q <= TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(pick);
            n_q <= cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(pick)];
            o_color_q <= 4'(pick);
            if (cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(pick)]
                >= CntW'(SLOTS_PER_COLOR)) o_status_q <= StatusFull;
            else begin
              o_slot_q <= 8'(cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal)
                + TabW'(pick)]);
              cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(pick)] <=
                cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(pick)] + 1'b1;
            end
          end else begin
            col_q <= ColW'(cmd_q.given_color);
            tab_q <= TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(cmd_q.given_color);
            n_q <= cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal)
              + TabW'(cmd_q.given_color)];
            o_color_q <= cmd_q.given_color;
            if (CntW'(cmd_q.given_slot) >= cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal)
                + TabW'(cmd_q.given_color)]) o_status_q <= StatusInvalid;
            else begin
              cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal) + TabW'(cmd_q.given_color)]
                <= cnt_q[TabW'(cmd_q.kind) * TabW'(ColorTotal)
                + TabW'(cmd_q.given_color)] - 1'b1;
              if (CntW'(cmd_q.given_slot) + CntW'(1) < cnt_q[TabW'(cmd_q.kind)
                  * TabW'(ColorTotal) + TabW'(cmd_q.given_color)]) begin
                o_moved_q <= 1'b1;
                o_slot_q <= cmd_q.given_slot;
              end
            end
          end
        end
        StMove: if (o_moved_q) o_id_q <= mid_q;
        StClear: begin
          for (int t = 0; t < int'(Tables); t++) cnt_q[t] <= '0;
          epoch_q <= (epoch_q == '1) ? EpochW'(1) : epoch_q + 1'b1;
          flush_pend_q <= 1'b0;
        end
        StOut: ;
        StWipe: wipe_q <= (wipe_q == BodyW'(BODY_COUNT - 1)) ? '0 : wipe_q + 1'b1;
        default: ;
      endcase
    end
  end

  `CGC_ASSERT(a_out_state, clk_i, rst_ni, !out_valid_o || st_q == StOut)
  `CGC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(o_slot_q))
  `CGC_ASSERT(a_moved_ok, clk_i, rst_ni, !(out_valid_o && o_moved_q) || o_status_q == StatusOk)
endmodule
`default_nettype wire

/* rtl/constraint_graph_colorer.sv */
// Top level of the constraint graph colorer
// Channel | Direction | Handshake            | Fields
// in      | input     | in_valid_i/in_stall_o | opcode..given_slot
// out     | output    | out_valid_o/out_stall_i | color, slot, moved_id, moved, status
// Each transaction passes the back-end states Idle, Read, Decide, Move and Out, and
// waits in Out while the output stalls; the back end takes the next one only in Idle.
// After a flush's own pass, the back end enters Clear from Idle, where counts clear and the mask epoch advances.
// Reset clears control, counts and queue, then a pass over the BODY_COUNT bodies (1024 by
// default) clears the mask tags; the same pass follows a flush that wraps the epoch.
// A two-entry queue lets the input side fill while the back end is stalled.
`timescale 1ns / 1ps
`default_nettype none
module constraint_graph_colorer import cgc_pkg::*; #(
  parameter int unsigned BODY_COUNT = BodyCountDef,
  parameter int unsigned STATIC_COLORS = StaticColorsDef,
  parameter int unsigned DYNAMIC_COLORS = DynamicColorsDef,
  parameter int unsigned SLOTS_PER_COLOR = SlotsPerColorDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic kind_i,
  input  wire logic [9:0] body_a_i,
  input  wire logic [9:0] body_b_i,
  input  wire logic dynamic_a_i,
  input  wire logic dynamic_b_i,
  input  wire logic [15:0] constraint_id_i,
  input  wire logic [3:0] given_color_i,
  input  wire logic [7:0] given_slot_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [3:0] color_o,
  output logic [7:0] slot_o,
  output logic [15:0] moved_id_o,
  output logic moved_o,
  output logic [1:0] status_o
);
  cmd_t cmd, q_cmd;
  logic q_valid, q_take;

  always_comb begin
    cmd.opcode = opcode_i;
    cmd.kind = kind_i;
    cmd.body_a = body_a_i;
    cmd.body_b = body_b_i;
    cmd.dynamic_a = dynamic_a_i;
    cmd.dynamic_b = dynamic_b_i;
    cmd.constraint_id = constraint_id_i;
    cmd.given_color = given_color_i;
    cmd.given_slot = given_slot_i;
    cmd.invalid = 1'b0;
  end

  cgc_front #(.BODY_COUNT(BODY_COUNT), .STATIC_COLORS(STATIC_COLORS),
    .DYNAMIC_COLORS(DYNAMIC_COLORS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i(cmd),
    .q_valid_o(q_valid), .q_take_i(q_take), .q_cmd_o(q_cmd));

  cgc_back #(.BODY_COUNT(BODY_COUNT), .STATIC_COLORS(STATIC_COLORS),
    .DYNAMIC_COLORS(DYNAMIC_COLORS), .SLOTS_PER_COLOR(SLOTS_PER_COLOR)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take), .q_cmd_i(q_cmd),
    .out_valid_o, .out_stall_i, .color_o, .slot_o, .moved_id_o, .moved_o, .status_o);
endmodule
`default_nettype wire
